[src/ttvp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the two-track vertex point block: field widths,
// status codes, saturation bounds and the cyclic index tables of the cross product.
// No dependencies.
package ttvp_pkg;

	// field widths
	localparam int POS_W   = 28;
	localparam int SLOPE_W = 19;
	localparam int CUT_W   = 20;
	localparam int STAT_W  = 2;

	// one quotient or root bit per step
	localparam int STEPS = POS_W;

	// reset value of the distance cut
	localparam logic [CUT_W-1:0] CUT_RESET = CUT_W'(1000);

	// result status codes
	localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAR      = 2'd1;
	localparam logic [STAT_W-1:0] ST_PARALLEL = 2'd2;

	// saturation bounds of a vertex coordinate
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// cyclic neighbors of an axis: cross(a,b)[k] = a[NEXT]*b[PREV] - a[PREV]*b[NEXT]
	localparam logic [1:0] NEXT [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] PREV [3] = '{2'd2, 2'd0, 2'd1};

endpackage

[src/two_track_vertex_point_top.sv]
`timescale 1ns / 1ps
// Two-track vertex point: closest distance, cut and midpoint vertex of two
// straight tracks. Depends on ttvp_pkg.
//
// The block takes one track pair in every clock cycle while in_stall is low
// and returns one result per pair, in order. The pipeline holds six multiply
// and sum stages, one offset and range stage, and 28 stages in which a
// restoring divider for each vertex axis and a root search for the distance
// each settle one bit, followed by the output register. A stall on the output
// freezes the whole pipeline, so the input stalls exactly while a finished
// item waits and is not taken. The distance cut is to be written through its
// own port only while the block is idle; the block itself does not enforce it.
module two_track_vertex_point_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ttvp_pkg::CUT_W-1:0]             cfg_data,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [ttvp_pkg::POS_W-1:0]      first_pos_x,
	input  logic signed [ttvp_pkg::POS_W-1:0]      first_pos_y,
	input  logic signed [ttvp_pkg::POS_W-1:0]      first_pos_z,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    first_slope_x,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    first_slope_y,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    first_slope_z,
	input  logic signed [ttvp_pkg::POS_W-1:0]      second_pos_x,
	input  logic signed [ttvp_pkg::POS_W-1:0]      second_pos_y,
	input  logic signed [ttvp_pkg::POS_W-1:0]      second_pos_z,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    second_slope_x,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    second_slope_y,
	input  logic signed [ttvp_pkg::SLOPE_W-1:0]    second_slope_z,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [ttvp_pkg::STAT_W-1:0]            status,
	output logic signed [ttvp_pkg::POS_W-1:0]      vertex_x,
	output logic signed [ttvp_pkg::POS_W-1:0]      vertex_y,
	output logic signed [ttvp_pkg::POS_W-1:0]      vertex_z,
	output logic [ttvp_pkg::POS_W-1:0]             closest_distance
);

	localparam int ST = ttvp_pkg::STEPS;

	// global advance: hold everything while a finished item is stalled
	logic adv;
	logic out_valid_q;
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// distance cut register
	logic [ttvp_pkg::CUT_W-1:0] cut_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= ttvp_pkg::CUT_RESET;
		end else if (cfg_valid) begin
			cut_q <= cfg_data;
		end
	end

	// gather input vectors
	logic signed [27:0] p1 [3], p2 [3];
	logic signed [18:0] d1 [3], d2 [3];
	assign p1 = '{first_pos_x, first_pos_y, first_pos_z};
	assign p2 = '{second_pos_x, second_pos_y, second_pos_z};
	assign d1 = '{first_slope_x, first_slope_y, first_slope_z};
	assign d2 = '{second_slope_x, second_slope_y, second_slope_z};

	// ---------------- stage 1: cross of slopes, point difference and sum
	logic               vld_s1;
	logic signed [37:0] c_s1 [3];
	logic signed [28:0] e_s1 [3], s_s1 [3];
	logic signed [18:0] d1_s1 [3], d2_s1 [3];
	logic signed [37:0] c_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c_c[k] = d1[ttvp_pkg::NEXT[k]] * d2[ttvp_pkg::PREV[k]]
			       - d1[ttvp_pkg::PREV[k]] * d2[ttvp_pkg::NEXT[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				c_s1[k]  <= c_c[k];
				e_s1[k]  <= 29'(p1[k]) - 29'(p2[k]);
				s_s1[k]  <= 29'(p1[k]) + 29'(p2[k]);
				d1_s1[k] <= d1[k];
				d2_s1[k] <= d2[k];
			end
		end
	end

	// ---------------- stage 2: squares, projections and point-slope crosses
	logic               vld_s2;
	logic [74:0]        csq_s2 [3];
	logic signed [66:0] ec_s2 [3];
	logic signed [48:0] ed1_s2 [3], ed2_s2 [3];
	logic signed [37:0] c_s2 [3];
	logic signed [28:0] s_s2 [3];
	logic signed [18:0] d1_s2 [3], d2_s2 [3];
	logic signed [75:0] csq_c [3];
	logic signed [66:0] ec_c [3];
	logic signed [48:0] ed1_c [3], ed2_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			csq_c[k] = c_s1[k] * c_s1[k];
			ec_c[k]  = e_s1[k] * c_s1[k];
			ed1_c[k] = e_s1[ttvp_pkg::NEXT[k]] * d1_s1[ttvp_pkg::PREV[k]]
			         - e_s1[ttvp_pkg::PREV[k]] * d1_s1[ttvp_pkg::NEXT[k]];
			ed2_c[k] = e_s1[ttvp_pkg::NEXT[k]] * d2_s1[ttvp_pkg::PREV[k]]
			         - e_s1[ttvp_pkg::PREV[k]] * d2_s1[ttvp_pkg::NEXT[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				csq_s2[k] <= csq_c[k][74:0];
				ec_s2[k]  <= ec_c[k];
				ed1_s2[k] <= ed1_c[k];
				ed2_s2[k] <= ed2_c[k];
				c_s2[k]   <= c_s1[k];
				s_s2[k]   <= s_s1[k];
				d1_s2[k]  <= d1_s1[k];
				d2_s2[k]  <= d2_s1[k];
			end
		end
	end

	// ---------------- stage 3: norm, projection sum, triple product partials
	logic               vld_s3;
	logic [75:0]        n2_s3;
	logic signed [68:0] m_s3;
	logic               par_s3;
	logic signed [62:0] pa1h_s3 [3], pa1l_s3 [3], pa2h_s3 [3], pa2l_s3 [3];
	logic signed [28:0] s_s3 [3];
	logic signed [18:0] d1_s3 [3], d2_s3 [3];
	logic [75:0]        n2_c;
	logic signed [68:0] m_c;
	logic signed [62:0] pa1h_c [3], pa1l_c [3], pa2h_c [3], pa2l_c [3];

	always_comb begin
		n2_c = 76'(csq_s2[0]) + 76'(csq_s2[1]) + 76'(csq_s2[2]);
		m_c  = 69'(ec_s2[0]) + 69'(ec_s2[1]) + 69'(ec_s2[2]);
		for (int k = 0; k < 3; k++) begin
			pa1h_c[k] = c_s2[k] * $signed(ed1_s2[k][48:24]);
			pa1l_c[k] = c_s2[k] * $signed({1'b0, ed1_s2[k][23:0]});
			pa2h_c[k] = c_s2[k] * $signed(ed2_s2[k][48:24]);
			pa2l_c[k] = c_s2[k] * $signed({1'b0, ed2_s2[k][23:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n2_s3  <= n2_c;
			m_s3   <= m_c;
			par_s3 <= (n2_c == '0);
			for (int k = 0; k < 3; k++) begin
				pa1h_s3[k] <= pa1h_c[k];
				pa1l_s3[k] <= pa1l_c[k];
				pa2h_s3[k] <= pa2h_c[k];
				pa2l_s3[k] <= pa2l_c[k];
				s_s3[k]    <= s_s2[k];
				d1_s3[k]   <= d1_s2[k];
				d2_s3[k]   <= d2_s2[k];
			end
		end
	end

	// ---------------- stage 4: square partials, solve numerators, norm times sum
	logic               vld_s4;
	logic [67:0]        hh_s4;
	logic [66:0]        hl_s4;
	logic [65:0]        ll_s4;
	logic signed [87:0] as_s4, at_s4;
	logic signed [55:0] nsp_s4 [3][3];
	logic [75:0]        n2_s4;
	logic               par_s4;
	logic signed [18:0] d1_s4 [3], d2_s4 [3];
	logic signed [68:0] mneg_c;
	logic [66:0]        mabs_c;
	logic signed [87:0] dot1_c, dot2_c;
	logic [25:0]        n2ch_c [3];
	logic signed [55:0] nsp_c [3][3];

	always_comb begin
		mneg_c = -m_s3;
		mabs_c = m_s3[68] ? mneg_c[66:0] : m_s3[66:0];
		dot1_c = '0;
		dot2_c = '0;
		for (int k = 0; k < 3; k++) begin
			dot1_c = dot1_c + (88'(pa1h_s3[k]) <<< 24) + 88'(pa1l_s3[k]);
			dot2_c = dot2_c + (88'(pa2h_s3[k]) <<< 24) + 88'(pa2l_s3[k]);
		end
		n2ch_c[0] = n2_s3[25:0];
		n2ch_c[1] = n2_s3[51:26];
		n2ch_c[2] = {2'b00, n2_s3[75:52]};
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				nsp_c[k][j] = $signed({1'b0, n2ch_c[j]}) * s_s3[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s4  <= mabs_c[66:33] * mabs_c[66:33];
			hl_s4  <= 67'(mabs_c[66:33]) * 67'(mabs_c[32:0]);
			ll_s4  <= mabs_c[32:0] * mabs_c[32:0];
			as_s4  <= -dot1_c;
			at_s4  <= -dot2_c;
			n2_s4  <= n2_s3;
			par_s4 <= par_s3;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					nsp_s4[k][j] <= nsp_c[k][j];
				end
				d1_s4[k] <= d1_s3[k];
				d2_s4[k] <= d2_s3[k];
			end
		end
	end

	// ---------------- stage 5: square of projection, norm times sum, slope partials
	logic               vld_s5;
	logic [133:0]       msq_s5;
	logic signed [107:0] ns_s5 [3];
	logic signed [48:0] asp_s5 [3][3], atp_s5 [3][3];
	logic [75:0]        n2_s5;
	logic               par_s5;
	logic signed [29:0] ach_c [3], atch_c [3];
	logic signed [48:0] asp_c [3][3], atp_c [3][3];

	always_comb begin
		ach_c[0]  = $signed({1'b0, as_s4[28:0]});
		ach_c[1]  = $signed({1'b0, as_s4[57:29]});
		ach_c[2]  = $signed(as_s4[87:58]);
		atch_c[0] = $signed({1'b0, at_s4[28:0]});
		atch_c[1] = $signed({1'b0, at_s4[57:29]});
		atch_c[2] = $signed(at_s4[87:58]);
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				asp_c[k][j] = ach_c[j] * d2_s4[k];
				atp_c[k][j] = atch_c[j] * d1_s4[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			msq_s5 <= (134'(hh_s4) << 66) + (134'(hl_s4) << 34) + 134'(ll_s4);
			n2_s5  <= n2_s4;
			par_s5 <= par_s4;
			for (int k = 0; k < 3; k++) begin
				ns_s5[k] <= 108'(nsp_s4[k][0]) + (108'(nsp_s4[k][1]) <<< 26)
				          + (108'(nsp_s4[k][2]) <<< 52);
				for (int j = 0; j < 3; j++) begin
					asp_s5[k][j] <= asp_c[k][j];
					atp_s5[k][j] <= atp_c[k][j];
				end
			end
		end
	end

	// ---------------- stage 6: full vertex numerators
	logic               vld_s6;
	logic signed [107:0] num_s6 [3];
	logic [133:0]       msq_s6;
	logic [75:0]        n2_s6;
	logic               par_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			msq_s6 <= msq_s5;
			n2_s6  <= n2_s5;
			par_s6 <= par_s5;
			for (int k = 0; k < 3; k++) begin
				num_s6[k] <= ns_s5[k]
				           + 108'(asp_s5[k][0]) + (108'(asp_s5[k][1]) <<< 29)
				           + (108'(asp_s5[k][2]) <<< 58)
				           + 108'(atp_s5[k][0]) + (108'(atp_s5[k][1]) <<< 29)
				           + (108'(atp_s5[k][2]) <<< 58);
			end
		end
	end

	// ---------------- stage 7 (step 0): offset numerator, range check
	// step arrays: index 0 is stage 7, index i holds the state after bit ST-i
	logic [104:0] rem_s [ST+1][3];
	logic [27:0]  quo_s [ST+1][3];
	logic [2:0]   shi_s [ST+1], slo_s [ST+1];
	logic [75:0]  n2_s  [ST+1];
	logic [133:0] msq_s [ST+1];
	logic [133:0] sqt_s [ST+1];
	logic [103:0] squ_s [ST+1];
	logic [27:0]  sqq_s [ST+1];
	logic         par_s [ST+1];
	logic         vld_s [ST+1];
	logic signed [109:0] numo_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			numo_c[k] = 110'(num_s6[k]) + $signed({6'b0, n2_s6, 28'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				rem_s[0][k] <= numo_c[k][104:0];
				quo_s[0][k] <= '0;
				slo_s[0][k] <= numo_c[k][109];
				shi_s[0][k] <= !numo_c[k][109]
				             && (numo_c[k][108:0] >= 109'({n2_s6, 29'b0}));
			end
			n2_s[0]  <= n2_s6;
			msq_s[0] <= msq_s6;
			sqt_s[0] <= '0;
			squ_s[0] <= '0;
			sqq_s[0] <= '0;
			par_s[0] <= par_s6;
		end
	end

	// ---------------- steps: one quotient bit per axis and one root bit per stage
	for (genvar i = 1; i <= ST; i++) begin : g_step
		localparam int B = ST - i;
		logic [104:0] dsh;
		logic [135:0] trial;
		logic         take;
		logic [104:0] rem_n [3];
		logic [27:0]  quo_n [3];

		always_comb begin
			dsh = 105'({n2_s[i-1], 1'b0}) << B;
			for (int k = 0; k < 3; k++) begin
				if (rem_s[i-1][k] >= dsh) begin
					rem_n[k] = rem_s[i-1][k] - dsh;
					quo_n[k] = quo_s[i-1][k] | (28'd1 << B);
				end else begin
					rem_n[k] = rem_s[i-1][k];
					quo_n[k] = quo_s[i-1][k];
				end
			end
			// (q + 2^B)^2 * n2 from q^2*n2 and q*n2
			trial = 136'(sqt_s[i-1]) + (136'(squ_s[i-1]) << (B + 1))
			      + (136'(n2_s[i-1]) << (2 * B));
			take  = (trial <= 136'(msq_s[i-1]));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 3; k++) begin
					rem_s[i][k] <= rem_n[k];
					quo_s[i][k] <= quo_n[k];
				end
				shi_s[i] <= shi_s[i-1];
				slo_s[i] <= slo_s[i-1];
				n2_s[i]  <= n2_s[i-1];
				msq_s[i] <= msq_s[i-1];
				par_s[i] <= par_s[i-1];
				if (take) begin
					sqt_s[i] <= trial[133:0];
					squ_s[i] <= squ_s[i-1] + (104'(n2_s[i-1]) << B);
					sqq_s[i] <= sqq_s[i-1] | (28'd1 << B);
				end else begin
					sqt_s[i] <= sqt_s[i-1];
					squ_s[i] <= squ_s[i-1];
					sqq_s[i] <= sqq_s[i-1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// ---------------- output register: status, saturation, cut decision
	logic [ttvp_pkg::STAT_W-1:0] status_q;
	logic signed [27:0]          vtx_q [3];
	logic [27:0]                 dist_q;
	logic                        reject_c;
	logic signed [27:0]          vtx_c [3];

	always_comb begin
		reject_c = (sqq_s[ST] > 28'(cut_q))
		        || ((sqq_s[ST] == 28'(cut_q)) && (sqt_s[ST] != msq_s[ST]));
		for (int k = 0; k < 3; k++) begin
			if (shi_s[ST][k]) begin
				vtx_c[k] = ttvp_pkg::POS_MAX;
			end else if (slo_s[ST][k]) begin
				vtx_c[k] = ttvp_pkg::POS_MIN;
			end else begin
				// quotient was offset by half the range: flip the top bit
				vtx_c[k] = $signed(quo_s[ST][k] ^ {1'b1, 27'b0});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (par_s[ST]) begin
				status_q <= ttvp_pkg::ST_PARALLEL;
				dist_q   <= '0;
				for (int k = 0; k < 3; k++) vtx_q[k] <= '0;
			end else if (reject_c) begin
				status_q <= ttvp_pkg::ST_FAR;
				dist_q   <= sqq_s[ST];
				for (int k = 0; k < 3; k++) vtx_q[k] <= '0;
			end else begin
				status_q <= ttvp_pkg::ST_FOUND;
				dist_q   <= sqq_s[ST];
				for (int k = 0; k < 3; k++) vtx_q[k] <= vtx_c[k];
			end
		end
	end

	// ---------------- valid bits of the front stages and the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s[0]    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s[0]    <= vld_s6;
			out_valid_q <= vld_s[ST];
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign vertex_x         = vtx_q[0];
	assign vertex_y         = vtx_q[1];
	assign vertex_z         = vtx_q[2];
	assign closest_distance = dist_q;

	// ---------------- assertions
	// parallel tracks carry no vertex and no distance
	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ttvp_pkg::ST_PARALLEL) |->
			(closest_distance == '0) && (vertex_x == '0) && (vertex_y == '0)
			&& (vertex_z == '0))
		else $error("parallel result carries data");

	// a rejected pair lies at or beyond the cut and has no vertex
	a_far_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ttvp_pkg::ST_FAR) |->
			(closest_distance >= 28'(cut_q)) && (vertex_x == '0)
			&& (vertex_y == '0) && (vertex_z == '0))
		else $error("rejected pair inside cut");

	// an accepted vertex lies within the cut
	a_found_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ttvp_pkg::ST_FOUND) |->
			(closest_distance <= 28'(cut_q)))
		else $error("vertex found beyond cut");

	// a stalled output freezes the last step of the pipeline
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_s[ST]) && $stable(sqq_s[ST]))
		else $error("pipeline moved under stall");

endmodule
